FILE: src/mvlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multilevel VLC table decoder package
// Shared types and fixed constants for the controller and datapath.
// ----------------------------------------------------------------------------
package mvlc_pkg;

    // Table word layout.
    localparam logic [3:0] POINTER_NIBBLE = 4'd12;
    localparam int         SYMBOL_BITS    = 12;
    localparam int         LENGTH_BITS    = 6;
    localparam int         OFFSET_BITS    = 10;
    localparam int         WORD_BITS      = 16;

    // Widest index that a pointer can ask for.
    localparam int         IDX_MAX_BITS   = 15;

    // Level counter codes.
    localparam logic [1:0] FIRST_LEVEL    = 2'd0;
    localparam logic [1:0] LAST_LEVEL     = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_LOOKUP,
        ST_EVAL
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture a new request
        logic write;    // store the captured word in the table
        logic advance;  // follow the pointer just read
        logic finish;   // present the result for one cycle
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_pointer;  // the word just read is a subtable pointer
        logic last_level;  // the word just read came from the third level
    } t_ctrl_status;

endpackage
`default_nettype wire

FILE: src/mvlc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module mvlc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage array with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: src/mvlc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multilevel VLC table decoder controller
// Sequences table writes and the chain of up to three table lookups.
// ----------------------------------------------------------------------------
module mvlc_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_operation,
    input  wire mvlc_pkg::t_ctrl_status i_status,
    output mvlc_pkg::t_ctrl_cmd        o_cmd,
    output logic                       o_busy
);

    mvlc_pkg::t_state r_state;
    mvlc_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mvlc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mvlc_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = i_operation ? mvlc_pkg::ST_WRITE : mvlc_pkg::ST_LOOKUP;
                end
            end
            mvlc_pkg::ST_WRITE: begin
                n_state = mvlc_pkg::ST_IDLE;
            end
            mvlc_pkg::ST_LOOKUP: begin
                n_state = mvlc_pkg::ST_EVAL;
            end
            mvlc_pkg::ST_EVAL: begin
                if (i_status.is_pointer && !i_status.last_level) begin
                    n_state = mvlc_pkg::ST_LOOKUP;
                end else begin
                    n_state = mvlc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mvlc_pkg::ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            mvlc_pkg::ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            mvlc_pkg::ST_WRITE: begin
                o_cmd.write  = 1'b1;
                o_cmd.finish = 1'b1;
            end
            mvlc_pkg::ST_LOOKUP: begin
                // The table read address is already on the RAM port.
                o_busy = 1'b1;
            end
            mvlc_pkg::ST_EVAL: begin
                if (i_status.is_pointer && !i_status.last_level) begin
                    o_cmd.advance = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                end
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: src/mvlc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multilevel VLC table decoder datapath
// Request registers, index extraction, address wrap, table RAM and result.
// ----------------------------------------------------------------------------
module mvlc_datapath #(
    parameter int TABLE_DEPTH      = 4096,
    parameter int FIRST_LEVEL_BITS = 9,
    parameter int WINDOW_BITS      = 40
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire mvlc_pkg::t_ctrl_cmd    i_cmd,
    input  wire logic                   i_operation,
    input  wire logic [11:0]            i_write_address,
    input  wire logic [15:0]            i_write_word,
    input  wire logic [11:0]            i_table_base,
    input  wire logic [WINDOW_BITS-1:0] i_bit_window,
    output mvlc_pkg::t_ctrl_status      o_status,
    output logic                        o_valid,
    output logic [11:0]                 o_symbol,
    output logic [5:0]                  o_code_length,
    output logic                        o_level_error
);

    localparam int AW        = $clog2(TABLE_DEPTH);
    // Enough conditional subtractions to reduce any 16-bit sum.
    localparam int RED_STEPS = $clog2(65536 / TABLE_DEPTH);
    localparam logic [5:0] POS_LIMIT = 6'((WINDOW_BITS < 63) ? WINDOW_BITS : 63);
    localparam logic [3:0] FIRST_WIDTH = 4'(FIRST_LEVEL_BITS);
    localparam logic [3:0] IDX_TOP     = 4'(mvlc_pkg::IDX_MAX_BITS);

    // Reduce a 16-bit value modulo the table depth by restoring subtraction.
    function automatic logic [AW-1:0] wrap_addr(input logic [15:0] value);
        logic [19:0] v;
        v = {4'b0, value};
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            if (v >= (20'(TABLE_DEPTH) << k)) begin
                v = v - (20'(TABLE_DEPTH) << k);
            end
        end
        return v[AW-1:0];
    endfunction

    logic [AW-1:0]                      r_base;
    logic [15:0]                        r_word;
    logic [WINDOW_BITS-1:0]             r_window;
    logic [3:0]                         r_width;
    logic [5:0]                         r_pos;
    logic [1:0]                         r_level;
    logic                               r_valid;
    logic [11:0]                        r_symbol;
    logic [5:0]                         r_length;
    logic                               r_error;

    logic [mvlc_pkg::IDX_MAX_BITS-1:0]  idx;
    logic [AW-1:0]                      lookup_addr;
    logic [AW-1:0]                      ram_addr;
    logic [15:0]                        rdata;
    logic                               is_pointer;
    logic [5:0]                         leaf_pos;
    logic [5:0]                         final_pos;

    // Next index: the top window bits, right-aligned to the current width.
    assign idx = r_window[WINDOW_BITS-1 -: mvlc_pkg::IDX_MAX_BITS] >> (IDX_TOP - r_width);
    assign lookup_addr = wrap_addr(16'(r_base) + 16'(idx));
    assign ram_addr    = i_cmd.write ? r_base : lookup_addr;

    mvlc_ram #(
        .WIDTH (mvlc_pkg::WORD_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_addr  (ram_addr),
        .i_wdata (r_word),
        .o_rdata (rdata)
    );

    // Classification of the word just read.
    assign is_pointer          = rdata[15:12] >= mvlc_pkg::POINTER_NIBBLE;
    assign o_status.is_pointer = is_pointer;
    assign o_status.last_level = r_level == mvlc_pkg::LAST_LEVEL;

    // Consumed length, saturated to the window size or 63, whichever is smaller.
    assign leaf_pos  = is_pointer ? r_pos : r_pos + {2'b0, rdata[15:12]};
    assign final_pos = (leaf_pos > POS_LIMIT) ? POS_LIMIT : leaf_pos;

    // Request and walk registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base   <= wrap_addr({4'b0, i_operation ? i_write_address : i_table_base});
            r_word   <= i_write_word;
            r_window <= i_bit_window;
            r_width  <= FIRST_WIDTH;
            r_pos    <= '0;
            r_level  <= mvlc_pkg::FIRST_LEVEL;
        end else if (i_cmd.advance) begin
            r_base   <= wrap_addr(16'(r_base)
                                  + {4'b0, rdata[mvlc_pkg::OFFSET_BITS-1:0], 2'b00});
            r_window <= r_window << r_width;
            r_pos    <= r_pos + {2'b0, r_width};
            r_width  <= rdata[13:10];
            r_level  <= r_level + 2'd1;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (i_cmd.write) begin
                r_symbol <= '0;
                r_length <= '0;
                r_error  <= 1'b0;
            end else if (is_pointer) begin
                r_symbol <= '0;
                r_length <= final_pos;
                r_error  <= 1'b1;
            end else begin
                r_symbol <= rdata[mvlc_pkg::SYMBOL_BITS-1:0];
                r_length <= final_pos;
                r_error  <= 1'b0;
            end
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    assign o_valid       = r_valid;
    assign o_symbol      = r_symbol;
    assign o_code_length = r_length;
    assign o_level_error = r_error;

endmodule
`default_nettype wire

FILE: src/multilevel_vlc_table_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multilevel VLC table decoder, top level
// Table-driven variable-length code decoder with up to three lookup levels.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A table write
// shows its all-zero result strobe after the ST_WRITE state; a decode
// that reads L table levels (L = 1 to 3) passes through ST_LOOKUP and
// ST_EVAL for each level and shows its result after the last ST_EVAL.
// Each level costs one read of the single-port table RAM plus an
// evaluation of its registered output, and each read depends on the one before it. The
// result is on the outputs for exactly one cycle under o_valid and must be
// taken then; a new request may be taken in that same cycle. The table
// contents are undefined until written, and there is no clearing pass.
module multilevel_vlc_table_decoder_top #(
    parameter int TABLE_DEPTH      = 4096,
    parameter int FIRST_LEVEL_BITS = 9,
    parameter int WINDOW_BITS      = 40
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   i_operation,
    input  wire logic [11:0]            i_write_address,
    input  wire logic [15:0]            i_write_word,
    input  wire logic [11:0]            i_table_base,
    input  wire logic [WINDOW_BITS-1:0] i_bit_window,
    output logic                        o_valid,
    output logic [11:0]                 o_symbol,
    output logic [5:0]                  o_code_length,
    output logic                        o_level_error
);

    mvlc_pkg::t_ctrl_cmd    cmd;
    mvlc_pkg::t_ctrl_status status;

    // Sequencer.
    mvlc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    // Table, address and result datapath.
    mvlc_datapath #(
        .TABLE_DEPTH      (TABLE_DEPTH),
        .FIRST_LEVEL_BITS (FIRST_LEVEL_BITS),
        .WINDOW_BITS      (WINDOW_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_operation     (i_operation),
        .i_write_address (i_write_address),
        .i_write_word    (i_write_word),
        .i_table_base    (i_table_base),
        .i_bit_window    (i_bit_window),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_symbol        (o_symbol),
        .o_code_length   (o_code_length),
        .o_level_error   (o_level_error)
    );

endmodule
`default_nettype wire

FILE: src/mvlc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multilevel VLC table decoder checker
// Port-level properties of the request and result timing.
// ----------------------------------------------------------------------------
module mvlc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [11:0] o_symbol,
    input wire logic        o_level_error
);

    // A taken request always keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a request was taken");

    // Results never come in consecutive cycles.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // A result follows a busy cycle and is shown with the block idle.
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) && !busy))
        else $error("result strobe without a preceding busy cycle");

    // A level error carries no symbol.
    a_error_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_level_error) |-> (o_symbol == 12'd0))
        else $error("level error reported with a nonzero symbol");

endmodule

bind multilevel_vlc_table_decoder_top mvlc_checker u_mvlc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_symbol      (o_symbol),
    .o_level_error (o_level_error)
);
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel VLC table decoder testbench
// A directed walk through table writes, wrapped addresses, two- and three-level
// chains and the third-level pointer error comes first. Random table fills and
// decodes follow, and their results are checked against a table predictor.
// ----------------------------------------------------------------------------
module tb;

    localparam int WINDOW_BITS      = 40;
    localparam int TABLE_DEPTH      = 4096;
    localparam int FIRST_LEVEL_BITS = 9;
    localparam int LENGTH_CAP       = (WINDOW_BITS < 63) ? WINDOW_BITS : 63;
    localparam int ITEM_TARGET      = 800;
    localparam int STALL_LIMIT      = 1000;
    localparam int DRAIN_CYCLES     = 10;
    localparam int BASE_POOL_SIZE   = 16;

    // Request operation codes.
    localparam logic OP_DECODE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    typedef struct packed {
        logic [11:0] symbol;
        logic [5:0]  code_length;
        logic        level_error;
    } t_vlc_result;

    localparam t_vlc_result RESULT_NONE = '0;

    typedef struct packed {
        logic                   op;
        logic [11:0]            addr;
        logic [15:0]            word;
        logic [11:0]            base;
        logic [WINDOW_BITS-1:0] window;
        logic                   typed;
        t_vlc_result            want;
    } t_stim_row;

    // Directed requests. Only entries written earlier in the list are read.
    localparam int DIR_ROWS = 22;
    localparam t_stim_row DIRECTED [0:DIR_ROWS-1] = '{
        // Plain first-level leaf, then decode at base zero.
        '{OP_WRITE,  12'h000, 16'h3ABC, 12'h000, 40'h00_0000_0000, 1'b1, RESULT_NONE},
        '{OP_DECODE, 12'h000, 16'h0000, 12'h000, 40'h00_0000_0000, 1'b1,
          '{12'hABC, 6'd3, 1'b0}},
        // Top address with the longest leaf, and an index that wraps past it.
        '{OP_WRITE,  12'hFFF, 16'hBFFF, 12'h000, 40'h00_0000_0000, 1'b1, RESULT_NONE},
        '{OP_DECODE, 12'h000, 16'h0000, 12'hFFF, 40'h00_0000_0000, 1'b1,
          '{12'hFFF, 6'd11, 1'b0}},
        '{OP_DECODE, 12'h000, 16'h0000, 12'hFFF, 40'h00_8000_0000, 1'b1,
          '{12'hABC, 6'd3, 1'b0}},
        // All-zero word is a leaf of length zero.
        '{OP_WRITE,  12'h001, 16'h0000, 12'h000, 40'h00_0000_0000, 1'b1, RESULT_NONE},
        '{OP_DECODE, 12'h000, 16'h0000, 12'h000, 40'h00_8000_0000, 1'b1,
          '{12'h000, 6'd0, 1'b0}},
        // Two-level chain with a 4-bit subtable index.
        '{OP_WRITE,  12'h002, 16'hD010, 12'h000, 40'h00_0000_0000, 1'b1, RESULT_NONE},
        '{OP_WRITE,  12'h045, 16'h5123, 12'h000, 40'h00_0000_0000, 1'b1, RESULT_NONE},
        '{OP_DECODE, 12'h000, 16'h0000, 12'h000, 40'h01_2800_0000, 1'b0, RESULT_NONE},
        // Zero-width pointer, full-width pointer, then a pointer at the third level.
        '{OP_WRITE,  12'h003, 16'hC020, 12'h000, 40'h00_0000_0000, 1'b1, RESULT_NONE},
        '{OP_WRITE,  12'h080, 16'hFFFF, 12'h000, 40'h00_0000_0000, 1'b1, RESULT_NONE},
        '{OP_WRITE,  12'h07C, 16'hC000, 12'h000, 40'h00_0000_0000, 1'b1, RESULT_NONE},
        '{OP_DECODE, 12'h000, 16'h0000, 12'h000, 40'h01_8000_0000, 1'b1,
          '{12'h000, 6'd9, 1'b1}},
        // Same chain ending in a third-level leaf.
        '{OP_WRITE,  12'h07C, 16'h7456, 12'h000, 40'h00_0000_0000, 1'b1, RESULT_NONE},
        '{OP_DECODE, 12'h000, 16'h0000, 12'h000, 40'h01_8000_0000, 1'b0, RESULT_NONE},
        // Longest code: two 15-bit subtable indexes and an 11-bit leaf.
        '{OP_WRITE,  12'h004, 16'hFC40, 12'h000, 40'h00_0000_0000, 1'b1, RESULT_NONE},
        '{OP_WRITE,  12'h100, 16'hFC40, 12'h000, 40'h00_0000_0000, 1'b1, RESULT_NONE},
        '{OP_WRITE,  12'h200, 16'hB001, 12'h000, 40'h00_0000_0000, 1'b1, RESULT_NONE},
        '{OP_DECODE, 12'h000, 16'h0000, 12'h000, 40'h02_0000_0000, 1'b0, RESULT_NONE},
        // All-ones window selects the last first-level entry.
        '{OP_WRITE,  12'h1FF, 16'h0FFF, 12'h000, 40'h00_0000_0000, 1'b1, RESULT_NONE},
        '{OP_DECODE, 12'h000, 16'h0000, 12'h000, 40'hFF_FFFF_FFFF, 1'b1,
          '{12'hFFF, 6'd0, 1'b0}}
    };

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   start           = 1'b0;
    logic                   i_operation     = OP_DECODE;
    logic [11:0]            i_write_address = '0;
    logic [15:0]            i_write_word    = '0;
    logic [11:0]            i_table_base    = '0;
    logic [WINDOW_BITS-1:0] i_bit_window    = '0;
    logic                   busy;
    logic                   o_valid;
    logic [11:0]            o_symbol;
    logic [5:0]             o_code_length;
    logic                   o_level_error;

    // Predictor copy of the code table and which entries hold a value.
    logic [15:0]   vlc_table   [TABLE_DEPTH];
    bit            vlc_written [TABLE_DEPTH];
    t_vlc_result   expected_codes [$];
    logic [11:0]   base_pool [$];
    int            items_sent   = 0;
    int            fail_count   = 0;
    int            stall_cycles = 0;
    bit            steady_sender = 1'b0;

    multilevel_vlc_table_decoder_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_write_address(i_write_address),
        .i_write_word   (i_write_word),
        .i_table_base   (i_table_base),
        .i_bit_window   (i_bit_window),
        .o_valid        (o_valid),
        .o_symbol       (o_symbol),
        .o_code_length  (o_code_length),
        .o_level_error  (o_level_error)
    );

    always #5 i_clk = ~i_clk;

    // Walk the table as the decoder does. Stops at the first entry that was never
    // written and reports its address, so that the caller can fill it first.
    function automatic void walk_code(input logic [11:0] base_in,
                                      input logic [WINDOW_BITS-1:0] window,
                                      output t_vlc_result res, output bit missing,
                                      output logic [11:0] miss_addr);
        int unsigned table_base;
        int unsigned index_bits;
        int unsigned pos;
        int unsigned index;
        int unsigned addr;
        int unsigned bit_pos;
        int unsigned lvl;
        int unsigned k;
        logic [15:0] entry;
        bit          done;
        res        = '0;
        missing    = 1'b0;
        miss_addr  = '0;
        table_base = base_in;
        index_bits = FIRST_LEVEL_BITS;
        pos        = 0;
        done       = 1'b0;
        for (lvl = 0; lvl <= mvlc_pkg::LAST_LEVEL && !done; lvl++) begin
            // Index bits beyond the end of the window read as zero.
            index = 0;
            for (k = 0; k < index_bits; k++) begin
                bit_pos = pos + k;
                index = (index << 1) |
                        ((bit_pos < WINDOW_BITS) ? window[WINDOW_BITS-1-bit_pos] : 1'b0);
            end
            addr = (table_base + index) % TABLE_DEPTH;
            if (!vlc_written[addr]) begin
                missing   = 1'b1;
                miss_addr = addr[11:0];
                done      = 1'b1;
            end else begin
                entry = vlc_table[addr];
                if (entry[15:12] >= mvlc_pkg::POINTER_NIBBLE) begin
                    if (lvl == mvlc_pkg::LAST_LEVEL) begin
                        res.level_error = 1'b1;
                        done = 1'b1;
                    end else begin
                        pos += index_bits;
                        index_bits = entry[13:10];
                        table_base = (table_base + {entry[9:0], 2'b00}) % TABLE_DEPTH;
                    end
                end else begin
                    pos += entry[15:12];
                    res.symbol = entry[11:0];
                    done = 1'b1;
                end
            end
        end
        if (pos > LENGTH_CAP) begin
            pos = LENGTH_CAP;
        end
        res.code_length = pos[5:0];
    endfunction

    // Random table word: mostly leaves, a good share of subtable pointers,
    // with small index widths favored so that codes stay within the window.
    function automatic logic [15:0] random_table_word();
        logic [3:0] index_bits;
        if ($urandom_range(99) < 35) begin
            index_bits = ($urandom_range(99) < 70) ? 4'($urandom_range(4)) :
                                                     4'($urandom_range(15));
            return {2'b11, index_bits, 10'($urandom)};
        end
        return {4'($urandom_range(11)), 12'($urandom)};
    endfunction

    // Present one request, wait until it is taken, then update the predictor.
    task automatic issue_request(input logic op, input logic [11:0] addr,
                                 input logic [15:0] word, input logic [11:0] base,
                                 input logic [WINDOW_BITS-1:0] window,
                                 input bit typed, input t_vlc_result typed_result);
        t_vlc_result want;
        bit          missing;
        logic [11:0] miss_addr;
        start           <= 1'b1;
        i_operation     <= op;
        i_write_address <= addr;
        i_write_word    <= word;
        i_table_base    <= base;
        i_bit_window    <= window;
        do @(posedge i_clk); while (busy);
        if (op == OP_WRITE) begin
            vlc_table[addr]   = word;
            vlc_written[addr] = 1'b1;
            want = RESULT_NONE;
        end else begin
            walk_code(base, window, want, missing, miss_addr);
        end
        if (typed) begin
            want = typed_result;
        end
        expected_codes.push_back(want);
        items_sent++;
        // Sender gap after the request, except in the steady stretch.
        if (!steady_sender && $urandom_range(99) < 15) begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
    endtask

    // Result checker and stall watchdog.
    always @(posedge i_clk) begin
        t_vlc_result want;
        if (i_rst_n) begin
            if (o_valid !== 1'b0) begin
                if (expected_codes.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    fail_count++;
                end else begin
                    want = expected_codes.pop_front();
                    if (o_symbol !== want.symbol) begin
                        $error("symbol: expected %0h, actual %0h", want.symbol, o_symbol);
                        fail_count++;
                    end
                    if (o_code_length !== want.code_length) begin
                        $error("code_length: expected %0d, actual %0d",
                               want.code_length, o_code_length);
                        fail_count++;
                    end
                    if (o_level_error !== want.level_error) begin
                        $error("level_error: expected %0b, actual %0b",
                               want.level_error, o_level_error);
                        fail_count++;
                    end
                end
            end
        end
        if ((start && !busy) || o_valid === 1'b1) begin
            stall_cycles = 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            stall_cycles++;
        end
    end

    // Stimulus: reset, directed table, random fills and decodes, then drain.
    initial begin
        int                     r;
        logic [11:0]            base;
        logic [WINDOW_BITS-1:0] window;
        t_vlc_result            want;
        bit                     missing;
        logic [11:0]            miss_addr;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < DIR_ROWS; r++) begin
            issue_request(DIRECTED[r].op, DIRECTED[r].addr, DIRECTED[r].word,
                          DIRECTED[r].base, DIRECTED[r].window,
                          DIRECTED[r].typed, DIRECTED[r].want);
        end

        while (items_sent < ITEM_TARGET) begin
            steady_sender = (items_sent >= 300 && items_sent < 450);
            window = WINDOW_BITS'({$urandom, $urandom});
            if ($urandom_range(99) < 12) begin
                // Stray write, possibly over a live entry.
                issue_request(OP_WRITE, 12'($urandom), random_table_word(),
                              12'($urandom), window, 1'b0, RESULT_NONE);
            end else begin
                // Reuse recent bases often so that decodes run through filled tables.
                if (base_pool.size() != 0 && $urandom_range(1) == 1) begin
                    base = base_pool[$urandom_range(base_pool.size() - 1)];
                end else begin
                    base = 12'($urandom);
                    base_pool.push_back(base);
                    if (base_pool.size() > BASE_POOL_SIZE) begin
                        void'(base_pool.pop_front());
                    end
                end
                // Fill every entry along the code path before decoding it.
                walk_code(base, window, want, missing, miss_addr);
                while (missing) begin
                    issue_request(OP_WRITE, miss_addr, random_table_word(),
                                  12'($urandom), WINDOW_BITS'({$urandom, $urandom}),
                                  1'b0, RESULT_NONE);
                    walk_code(base, window, want, missing, miss_addr);
                end
                issue_request(OP_DECODE, 12'($urandom), 16'($urandom), base, window,
                              1'b0, RESULT_NONE);
            end
        end
        start <= 1'b0;

        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
